[rtl/core/jsu_pkg.sv]
// jsu_pkg: shared types and constants of the json string unescape unit
// holds transaction structs, decoder mode and command encodings
// no dependencies
package jsu_pkg;

    // input transaction: one body byte or the end of the text
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } in_item_t;

    // output transaction: one decoded byte, a close marker or an error
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [2:0] error_code;
        logic       last;
    } out_item_t;

    // result kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // error codes
    localparam logic [2:0] ERR_UNTERM_STRING = 3'd0;
    localparam logic [2:0] ERR_CONTROL_CHAR  = 3'd1;
    localparam logic [2:0] ERR_UNTERM_ESCAPE = 3'd2;
    localparam logic [2:0] ERR_UNKNOWN_ESC   = 3'd3;
    localparam logic [2:0] ERR_TRUNC_HEX     = 3'd4;
    localparam logic [2:0] ERR_BAD_HEX       = 3'd5;

    // decoder modes
    typedef enum logic [2:0] {
        MODE_PLAIN  = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_HEX    = 3'd2,
        MODE_LEAD   = 3'd3,
        MODE_LEADBS = 3'd4,
        MODE_HEX2   = 3'd5
    } mode_t;

    // main action of one command
    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_BYTE  = 3'd1,
        ACT_CP    = 3'd2,
        ACT_CLOSE = 3'd3,
        ACT_ERR   = 3'd4
    } act_t;

    localparam int CP_W = 21;

    // command from front to back: optional U+FFFD, then the main action
    typedef struct packed {
        logic              pre_fffd;
        act_t              act;
        logic [CP_W-1:0]   val;
        logic [2:0]        code;
    } cmd_t;

    // command queue geometry
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    typedef struct packed {
        logic                 full;
        logic                 empty;
        logic [CMD_CNT_W-1:0] count;
    } fifo_stat_t;

    // characters
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    // code point constants
    localparam logic [15:0] SUR_LEAD_LO  = 16'hD800;
    localparam logic [15:0] SUR_LEAD_HI  = 16'hDBFF;
    localparam logic [15:0] SUR_TRAIL_LO = 16'hDC00;
    localparam logic [15:0] SUR_TRAIL_HI = 16'hDFFF;
    localparam logic [CP_W-1:0] CP_REPL  = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_SUPP  = 21'h010000;

    // utf-8 bytes of U+FFFD
    localparam logic [7:0] REPL_B0 = 8'hEF;
    localparam logic [7:0] REPL_B1 = 8'hBF;
    localparam logic [7:0] REPL_B2 = 8'hBD;

    localparam logic [7:0] UTF_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF_LEAD4 = 8'hF0;
    localparam logic [7:0] UTF_CONT  = 8'h80;

endpackage

[rtl/core/json_string_unescape_unit.sv]
// json_string_unescape_unit: top level of the json string body decoder
// instantiates jsu_front, jsu_cmd_fifo and jsu_back; depends on jsu_pkg
//
// Feed the bytes of one JSON string body, starting after the opening quote,
// one per push; raise end_of_input in place of a byte when the text ends.
// The front end takes one byte per cycle whenever its 4-entry command queue
// has room (full low) and resolves escapes, hex digits and surrogate pairs
// in that cycle. The back end delivers one result per cycle while pop is
// held: a decoded byte, a close marker or an error, with last set on the
// final result of each input byte. A byte may give several results (plain
// text: one, an escaped code point: up to six), and the back end holds its
// command until all of them are popped; the sustained rate is set by the
// single output port of the back end. Bytes that produce no result
// (backslash, hex digits) are taken at the input and give nothing at the
// output. After a close marker or an error the decoder is back in plain text
// mode. Each command passes the command queue, then the back end's register.
module json_string_unescape_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  jsu_pkg::in_item_t   item,
    output logic                empty,
    input  logic                pop,
    output jsu_pkg::out_item_t  result
);
    import jsu_pkg::*;

    logic       accept;
    logic       cmd_valid;
    cmd_t       front_cmd;
    cmd_t       head_cmd;
    logic       take;
    fifo_stat_t fifo_stat;

    assign full   = fifo_stat.full;
    assign accept = push && !fifo_stat.full;

    // byte classification and escape state
    jsu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (front_cmd)
    );

    // command queue
    jsu_cmd_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_valid),
        .wr_cmd (front_cmd),
        .rd_en  (take),
        .rd_cmd (head_cmd),
        .stat   (fifo_stat)
    );

    // result expansion
    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_cmd   (head_cmd),
        .head_valid (!fifo_stat.empty),
        .take       (take),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

    // queue occupancy stays within its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        fifo_stat.count <= CMD_CNT_W'(CMD_DEPTH))
        else $error("command queue overflow");

    // a waiting command reaches the output on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (!fifo_stat.empty && empty) |=> !empty)
        else $error("back end did not load a waiting command");

    // non-byte results carry a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.kind != KIND_BYTE)) |-> (result.out_byte == 8'd0))
        else $error("nonzero byte on a marker or error");

    // only errors carry an error code
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.kind != KIND_ERROR)) |-> (result.error_code == ERR_UNTERM_STRING))
        else $error("error code on a non-error result");

endmodule

[rtl/core/jsu_front.sv]
// jsu_front: accepts body bytes, runs the escape state machine and
// turns each byte into at most one command for the back end
// depends on jsu_pkg
module jsu_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  jsu_pkg::in_item_t item,
    output logic              cmd_valid,
    output jsu_pkg::cmd_t     cmd
);
    import jsu_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [15:0] hv_reg, hv_next;
    logic [1:0]  hc_reg, hc_next;
    logic        hb_reg, hb_next;
    logic [9:0]  lead_reg, lead_next;

    logic [7:0]  b;

    // plain byte classification
    act_t            p_act;
    logic [CP_W-1:0] p_val;
    logic [2:0]      p_code;
    logic            p_clear;
    logic            p_esc;

    // escape byte classification
    act_t            e_act;
    logic [CP_W-1:0] e_val;
    logic [2:0]      e_code;
    logic            e_hex;
    logic            e_clear;

    // hex digit
    logic [3:0]      digit;
    logic            digit_bad;
    logic [15:0]     hv_shift;
    logic            bad_any;
    logic            is_lead;
    logic            is_trail;
    logic [CP_W-1:0] combined;

    assign b = item.data_byte;

    // plain text byte
    always_comb
    begin
        p_act   = ACT_NONE;
        p_val   = '0;
        p_code  = ERR_UNTERM_STRING;
        p_clear = 1'b0;
        p_esc   = 1'b0;
        if (b == CH_QUOTE)
        begin
            p_act   = ACT_CLOSE;
            p_clear = 1'b1;
        end
        else if (b < CH_SPACE)
        begin
            p_act   = ACT_ERR;
            p_code  = ERR_CONTROL_CHAR;
            p_clear = 1'b1;
        end
        else if (b == CH_BSLASH)
        begin
            p_esc = 1'b1;
        end
        else
        begin
            p_act = ACT_BYTE;
            p_val = {{(CP_W-8){1'b0}}, b};
        end
    end

    // byte after a backslash
    always_comb
    begin
        e_act   = ACT_BYTE;
        e_val   = '0;
        e_code  = ERR_UNTERM_STRING;
        e_hex   = 1'b0;
        e_clear = 1'b0;
        case (b)
            CH_QUOTE:  e_val = {{(CP_W-8){1'b0}}, CH_QUOTE};
            CH_BSLASH: e_val = {{(CP_W-8){1'b0}}, CH_BSLASH};
            CH_SLASH:  e_val = {{(CP_W-8){1'b0}}, CH_SLASH};
            CH_B:      e_val = {{(CP_W-8){1'b0}}, 8'h08};
            CH_F:      e_val = {{(CP_W-8){1'b0}}, 8'h0C};
            CH_N:      e_val = {{(CP_W-8){1'b0}}, 8'h0A};
            CH_R:      e_val = {{(CP_W-8){1'b0}}, 8'h0D};
            CH_T:      e_val = {{(CP_W-8){1'b0}}, 8'h09};
            CH_U:
            begin
                e_act = ACT_NONE;
                e_hex = 1'b1;
            end
            default:
            begin
                e_act   = ACT_ERR;
                e_code  = ERR_UNKNOWN_ESC;
                e_clear = 1'b1;
            end
        endcase
    end

    // hex digit decode and surrogate tests on the completed value
    always_comb
    begin
        digit     = 4'd0;
        digit_bad = 1'b0;
        if (b inside {[8'h30:8'h39]})
            digit = b[3:0];
        else if (b inside {[8'h61:8'h66], [8'h41:8'h46]})
            digit = b[3:0] + 4'd9;
        else
            digit_bad = 1'b1;
    end

    assign hv_shift = {hv_reg[11:0], digit};
    assign bad_any  = hb_reg | digit_bad;
    assign is_lead  = (hv_shift >= SUR_LEAD_LO) && (hv_shift <= SUR_LEAD_HI);
    assign is_trail = (hv_shift >= SUR_TRAIL_LO) && (hv_shift <= SUR_TRAIL_HI);
    assign combined = CP_SUPP + {1'b0, lead_reg, hv_shift[9:0]};

    // next state and command
    always_comb
    begin
        mode_next     = mode_reg;
        hv_next       = hv_reg;
        hc_next       = hc_reg;
        hb_next       = hb_reg;
        lead_next     = lead_reg;
        cmd.pre_fffd  = 1'b0;
        cmd.act       = ACT_NONE;
        cmd.val       = '0;
        cmd.code      = ERR_UNTERM_STRING;

        if (item.end_of_input)
        begin
            cmd.act   = ACT_ERR;
            mode_next = MODE_PLAIN;
            hv_next   = '0;
            hc_next   = '0;
            hb_next   = 1'b0;
            lead_next = '0;
            case (mode_reg)
                MODE_ESC:    cmd.code = ERR_UNTERM_ESCAPE;
                MODE_HEX,
                MODE_HEX2:   cmd.code = ERR_TRUNC_HEX;
                MODE_LEAD:
                begin
                    cmd.pre_fffd = 1'b1;
                    cmd.code     = ERR_UNTERM_STRING;
                end
                MODE_LEADBS:
                begin
                    cmd.pre_fffd = 1'b1;
                    cmd.code     = ERR_UNTERM_ESCAPE;
                end
                default:     cmd.code = ERR_UNTERM_STRING;
            endcase
        end
        else
        begin
            case (mode_reg)
                MODE_ESC:
                begin
                    cmd.act  = e_act;
                    cmd.val  = e_val;
                    cmd.code = e_code;
                    if (e_hex)
                    begin
                        mode_next = MODE_HEX;
                        hv_next   = '0;
                        hc_next   = '0;
                        hb_next   = 1'b0;
                    end
                    else if (e_clear)
                    begin
                        mode_next = MODE_PLAIN;
                        hv_next   = '0;
                        hc_next   = '0;
                        hb_next   = 1'b0;
                        lead_next = '0;
                    end
                    else
                    begin
                        mode_next = MODE_PLAIN;
                    end
                end
                MODE_HEX,
                MODE_HEX2:
                begin
                    hv_next = hv_shift;
                    hb_next = bad_any;
                    if (hc_reg != 2'd3)
                    begin
                        hc_next = hc_reg + 2'd1;
                    end
                    else if (bad_any)
                    begin
                        cmd.act   = ACT_ERR;
                        cmd.code  = ERR_BAD_HEX;
                        mode_next = MODE_PLAIN;
                        hv_next   = '0;
                        hc_next   = '0;
                        hb_next   = 1'b0;
                        lead_next = '0;
                    end
                    else
                    begin
                        hv_next = '0;
                        hc_next = '0;
                        if ((mode_reg == MODE_HEX2) && is_trail)
                        begin
                            // lead and trail pair into one code point
                            cmd.act   = ACT_CP;
                            cmd.val   = combined;
                            lead_next = '0;
                            mode_next = MODE_PLAIN;
                        end
                        else
                        begin
                            if (mode_reg == MODE_HEX2)
                            begin
                                cmd.pre_fffd = 1'b1;
                                lead_next    = '0;
                            end
                            if (is_lead)
                            begin
                                lead_next = hv_shift[9:0];
                                mode_next = MODE_LEAD;
                            end
                            else if (is_trail)
                            begin
                                cmd.act   = ACT_CP;
                                cmd.val   = CP_REPL;
                                mode_next = MODE_PLAIN;
                            end
                            else
                            begin
                                cmd.act   = ACT_CP;
                                cmd.val   = {{(CP_W-16){1'b0}}, hv_shift};
                                mode_next = MODE_PLAIN;
                            end
                        end
                    end
                end
                MODE_LEADBS:
                begin
                    if (b == CH_U)
                    begin
                        mode_next = MODE_HEX2;
                        hv_next   = '0;
                        hc_next   = '0;
                        hb_next   = 1'b0;
                    end
                    else
                    begin
                        // unpaired lead, then the escape on its own
                        cmd.pre_fffd = 1'b1;
                        cmd.act      = e_act;
                        cmd.val      = e_val;
                        cmd.code     = e_code;
                        lead_next    = '0;
                        mode_next    = MODE_PLAIN;
                        if (e_hex)
                        begin
                            mode_next = MODE_HEX;
                            hv_next   = '0;
                            hc_next   = '0;
                            hb_next   = 1'b0;
                        end
                        else if (e_clear)
                        begin
                            hv_next = '0;
                            hc_next = '0;
                            hb_next = 1'b0;
                        end
                    end
                end
                MODE_LEAD:
                begin
                    if (b == CH_BSLASH)
                    begin
                        mode_next = MODE_LEADBS;
                    end
                    else
                    begin
                        // unpaired lead, then the byte as plain text
                        cmd.pre_fffd = 1'b1;
                        cmd.act      = p_act;
                        cmd.val      = p_val;
                        cmd.code     = p_code;
                        lead_next    = '0;
                        mode_next    = MODE_PLAIN;
                        if (p_clear)
                        begin
                            hv_next = '0;
                            hc_next = '0;
                            hb_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                    cmd.act   = p_act;
                    cmd.val   = p_val;
                    cmd.code  = p_code;
                    mode_next = p_esc ? MODE_ESC : MODE_PLAIN;
                    if (p_clear)
                    begin
                        hv_next   = '0;
                        hc_next   = '0;
                        hb_next   = 1'b0;
                        lead_next = '0;
                    end
                end
            endcase
        end
    end

    // only transactions that produce results go into the queue
    assign cmd_valid = accept && (cmd.pre_fffd || (cmd.act != ACT_NONE));

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_PLAIN;
            hv_reg   <= '0;
            hc_reg   <= '0;
            hb_reg   <= 1'b0;
            lead_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            hv_reg   <= hv_next;
            hc_reg   <= hc_next;
            hb_reg   <= hb_next;
            lead_reg <= lead_next;
        end
    end

endmodule

[rtl/core/jsu_cmd_fifo.sv]
// jsu_cmd_fifo: short command queue between front and back end
// register based, one write and one read per cycle
// depends on jsu_pkg
module jsu_cmd_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  jsu_pkg::cmd_t        wr_cmd,
    input  logic                 rd_en,
    output jsu_pkg::cmd_t        rd_cmd,
    output jsu_pkg::fifo_stat_t  stat
);
    import jsu_pkg::*;

    cmd_t                 entry_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg, count_next;
    logic                 do_wr;
    logic                 do_rd;

    assign stat.full  = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;
    assign rd_cmd     = entry_reg[rd_ptr_reg];

    assign do_wr = wr_en && !stat.full;
    assign do_rd = rd_en && !stat.empty;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_cmd;
    end

endmodule

[rtl/core/jsu_back.sv]
// jsu_back: expands one command into its result transactions,
// one per cycle while pop is high, including utf-8 encoding of code points
// depends on jsu_pkg
module jsu_back (
    input  logic                clk,
    input  logic                rst_n,
    input  jsu_pkg::cmd_t       head_cmd,
    input  logic                head_valid,
    output logic                take,
    output logic                empty,
    input  logic                pop,
    output jsu_pkg::out_item_t  result
);
    import jsu_pkg::*;

    cmd_t       cmd_reg;
    logic       valid_reg;
    logic [2:0] idx_reg;
    logic [2:0] pre_len;
    logic [2:0] main_len;
    logic [2:0] total_len;
    logic [2:0] sub_idx;
    logic       is_last;
    logic       pop_ok;
    logic [7:0] cp_byte;

    // result counts for the held command
    always_comb
    begin
        pre_len = cmd_reg.pre_fffd ? 3'd3 : 3'd0;
        case (cmd_reg.act)
            ACT_NONE:  main_len = 3'd0;
            ACT_CP:
            begin
                if (cmd_reg.val < 21'h80)
                    main_len = 3'd1;
                else if (cmd_reg.val < 21'h800)
                    main_len = 3'd2;
                else if (cmd_reg.val < 21'h10000)
                    main_len = 3'd3;
                else
                    main_len = 3'd4;
            end
            default:   main_len = 3'd1;
        endcase
    end

    assign total_len = pre_len + main_len;
    assign sub_idx   = idx_reg - pre_len;
    assign is_last   = (idx_reg == total_len - 3'd1);

    // utf-8 byte selection
    always_comb
    begin
        cp_byte = '0;
        case (main_len)
            3'd1: cp_byte = cmd_reg.val[7:0];
            3'd2:
            begin
                if (sub_idx == 3'd0)
                    cp_byte = UTF_LEAD2 | {3'b000, cmd_reg.val[10:6]};
                else
                    cp_byte = UTF_CONT | {2'b00, cmd_reg.val[5:0]};
            end
            3'd3:
            begin
                if (sub_idx == 3'd0)
                    cp_byte = UTF_LEAD3 | {4'b0000, cmd_reg.val[15:12]};
                else if (sub_idx == 3'd1)
                    cp_byte = UTF_CONT | {2'b00, cmd_reg.val[11:6]};
                else
                    cp_byte = UTF_CONT | {2'b00, cmd_reg.val[5:0]};
            end
            3'd4:
            begin
                if (sub_idx == 3'd0)
                    cp_byte = UTF_LEAD4 | {5'b00000, cmd_reg.val[20:18]};
                else if (sub_idx == 3'd1)
                    cp_byte = UTF_CONT | {2'b00, cmd_reg.val[17:12]};
                else if (sub_idx == 3'd2)
                    cp_byte = UTF_CONT | {2'b00, cmd_reg.val[11:6]};
                else
                    cp_byte = UTF_CONT | {2'b00, cmd_reg.val[5:0]};
            end
            default: cp_byte = '0;
        endcase
    end

    // result fields
    always_comb
    begin
        result.out_byte   = '0;
        result.kind       = KIND_BYTE;
        result.error_code = ERR_UNTERM_STRING;
        result.last       = is_last;
        if (cmd_reg.pre_fffd && (idx_reg < 3'd3))
        begin
            case (idx_reg)
                3'd0:    result.out_byte = REPL_B0;
                3'd1:    result.out_byte = REPL_B1;
                default: result.out_byte = REPL_B2;
            endcase
        end
        else
        begin
            case (cmd_reg.act)
                ACT_BYTE:  result.out_byte = cmd_reg.val[7:0];
                ACT_CP:    result.out_byte = cp_byte;
                ACT_CLOSE: result.kind = KIND_CLOSE;
                ACT_ERR:
                begin
                    result.kind       = KIND_ERROR;
                    result.error_code = cmd_reg.code;
                end
                default:   result.out_byte = '0;
            endcase
        end
    end

    // load the next command as the current one drains
    assign empty  = !valid_reg;
    assign pop_ok = pop && valid_reg;
    assign take   = head_valid && (!valid_reg || (pop_ok && is_last));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (pop_ok)
        begin
            if (is_last)
                valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            cmd_reg <= head_cmd;
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// tb: self-checking testbench of json_string_unescape_unit, the json string body decoder
// predicts every decoded byte, close marker and error from its own decoder model
// depends on jsu_pkg and the unit's rtl
module tb;
    import jsu_pkg::*;

    localparam int          RANDOM_ITEMS = 405;
    localparam int          PAUSE_AT     = 200;
    localparam int          LONG_HOLD    = 120;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam logic [2:0]  NO_CODE      = 3'd0;

    // directed stimulus row; want fields are used only when typed is set
    typedef struct packed {
        logic [7:0] data;
        logic       eoi;
        logic       typed;
        logic [7:0] wbyte;
        logic [1:0] wkind;
        logic [2:0] wcode;
    } step_row_t;

    localparam step_row_t DIRECTED [25] = '{
        '{8'h41, 1'b0, 1'b1, 8'h41, KIND_BYTE,  NO_CODE},
        '{8'hFF, 1'b0, 1'b1, 8'hFF, KIND_BYTE,  NO_CODE},
        '{8'h1F, 1'b0, 1'b1, 8'h00, KIND_ERROR, ERR_CONTROL_CHAR},
        '{8'h22, 1'b0, 1'b1, 8'h00, KIND_CLOSE, NO_CODE},
        '{8'h5C, 1'b0, 1'b0, 8'h00, KIND_BYTE,  NO_CODE},
        '{8'h71, 1'b0, 1'b1, 8'h00, KIND_ERROR, ERR_UNKNOWN_ESC},
        // lead surrogate d83d, then trail de00
        '{8'h5C, 1'b0, 1'b0, 8'h00, KIND_BYTE,  NO_CODE},
        '{8'h75, 1'b0, 1'b0, 8'h00, KIND_BYTE,  NO_CODE},
        '{8'h44, 1'b0, 1'b0, 8'h00, KIND_BYTE,  NO_CODE},
        '{8'h38, 1'b0, 1'b0, 8'h00, KIND_BYTE,  NO_CODE},
        '{8'h33, 1'b0, 1'b0, 8'h00, KIND_BYTE,  NO_CODE},
        '{8'h64, 1'b0, 1'b0, 8'h00, KIND_BYTE,  NO_CODE},
        '{8'h5C, 1'b0, 1'b0, 8'h00, KIND_BYTE,  NO_CODE},
        '{8'h75, 1'b0, 1'b0, 8'h00, KIND_BYTE,  NO_CODE},
        '{8'h44, 1'b0, 1'b0, 8'h00, KIND_BYTE,  NO_CODE},
        '{8'h45, 1'b0, 1'b0, 8'h00, KIND_BYTE,  NO_CODE},
        '{8'h30, 1'b0, 1'b0, 8'h00, KIND_BYTE,  NO_CODE},
        '{8'h30, 1'b0, 1'b0, 8'h00, KIND_BYTE,  NO_CODE},
        // bad digit, then the text ends inside the escape
        '{8'h5C, 1'b0, 1'b0, 8'h00, KIND_BYTE,  NO_CODE},
        '{8'h75, 1'b0, 1'b0, 8'h00, KIND_BYTE,  NO_CODE},
        '{8'h47, 1'b0, 1'b0, 8'h00, KIND_BYTE,  NO_CODE},
        '{8'hFF, 1'b1, 1'b1, 8'h00, KIND_ERROR, ERR_TRUNC_HEX},
        '{8'h5C, 1'b0, 1'b0, 8'h00, KIND_BYTE,  NO_CODE},
        '{8'h00, 1'b1, 1'b1, 8'h00, KIND_ERROR, ERR_UNTERM_ESCAPE},
        '{8'hA5, 1'b1, 1'b1, 8'h00, KIND_ERROR, ERR_UNTERM_STRING}
    };

    localparam logic [7:0] SIMPLE_ESC [8] =
        '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
    localparam logic [15:0] EDGE_CP [8] =
        '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF};

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    in_item_t   item;
    logic       empty;
    logic       pop;
    out_item_t  result;

    // decoder model state
    mode_t       dec_mode;
    logic [15:0] hex_acc;
    logic [1:0]  hex_n;
    logic        hex_err;
    logic [9:0]  lead_hold;

    out_item_t   step_res[$];
    out_item_t   decoded_due[$];
    in_item_t    plan_q[$];

    int          errors;
    int          burst_left;
    int          cycle_count;
    bit          hold_req;

    json_string_unescape_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // decoder model
    // ---------------------------------------------------------------

    function automatic void clear_decoder();
        dec_mode  = MODE_PLAIN;
        hex_acc   = '0;
        hex_n     = '0;
        hex_err   = 1'b0;
        lead_hold = '0;
    endfunction

    function automatic void add_res(logic [7:0] b, logic [1:0] k, logic [2:0] c);
        out_item_t r;
        r.out_byte   = b;
        r.kind       = k;
        r.error_code = c;
        r.last       = 1'b0;
        step_res     = {step_res, r};
    endfunction

    function automatic void add_err(logic [2:0] c);
        add_res(8'h00, KIND_ERROR, c);
        clear_decoder();
    endfunction

    // utf-8 encoding of one code point
    function automatic void put_cp(logic [20:0] cp);
        if (cp < 21'h80)
        begin
            add_res(cp[7:0], KIND_BYTE, NO_CODE);
        end
        else if (cp < 21'h800)
        begin
            add_res(UTF_LEAD2 | 8'(cp[10:6]), KIND_BYTE, NO_CODE);
            add_res(UTF_CONT | 8'(cp[5:0]), KIND_BYTE, NO_CODE);
        end
        else if (cp < CP_SUPP)
        begin
            add_res(UTF_LEAD3 | 8'(cp[15:12]), KIND_BYTE, NO_CODE);
            add_res(UTF_CONT | 8'(cp[11:6]), KIND_BYTE, NO_CODE);
            add_res(UTF_CONT | 8'(cp[5:0]), KIND_BYTE, NO_CODE);
        end
        else
        begin
            add_res(UTF_LEAD4 | 8'(cp[20:18]), KIND_BYTE, NO_CODE);
            add_res(UTF_CONT | 8'(cp[17:12]), KIND_BYTE, NO_CODE);
            add_res(UTF_CONT | 8'(cp[11:6]), KIND_BYTE, NO_CODE);
            add_res(UTF_CONT | 8'(cp[5:0]), KIND_BYTE, NO_CODE);
        end
    endfunction

    function automatic logic hex_nibble(input logic [7:0] b, output logic [3:0] d);
        d = 4'h0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            d = 4'(b - 8'h30);
            return 1'b1;
        end
        if (b >= 8'h61 && b <= 8'h66)
        begin
            d = 4'(b - 8'h61 + 8'd10);
            return 1'b1;
        end
        if (b >= 8'h41 && b <= 8'h46)
        begin
            d = 4'(b - 8'h41 + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void open_hex(mode_t m);
        dec_mode = m;
        hex_acc  = '0;
        hex_n    = '0;
        hex_err  = 1'b0;
    endfunction

    // one digit of a \u escape; the fourth digit resolves the code point
    function automatic void take_hex_digit(logic [7:0] b);
        logic [3:0]  d;
        logic [15:0] cp;
        if (!hex_nibble(b, d))
            hex_err = 1'b1;
        hex_acc = {hex_acc[11:0], d};
        if (hex_n != 2'd3)
        begin
            hex_n = hex_n + 2'd1;
            return;
        end
        if (hex_err)
        begin
            add_err(ERR_BAD_HEX);
            return;
        end
        cp      = hex_acc;
        hex_acc = '0;
        hex_n   = '0;
        // second half of a pair, or a lone lead resolved by a non-trail
        if (dec_mode == MODE_HEX2)
        begin
            if (cp >= SUR_TRAIL_LO && cp <= SUR_TRAIL_HI)
            begin
                put_cp(CP_SUPP + {1'b0, lead_hold, 10'b0} + 21'(cp - SUR_TRAIL_LO));
                lead_hold = '0;
                dec_mode  = MODE_PLAIN;
                return;
            end
            lead_hold = '0;
            put_cp(CP_REPL);
        end
        if (cp >= SUR_LEAD_LO && cp <= SUR_LEAD_HI)
        begin
            lead_hold = cp[9:0];
            dec_mode  = MODE_LEAD;
        end
        else if (cp >= SUR_TRAIL_LO && cp <= SUR_TRAIL_HI)
        begin
            dec_mode = MODE_PLAIN;
            put_cp(CP_REPL);
        end
        else
        begin
            dec_mode = MODE_PLAIN;
            put_cp(21'(cp));
        end
    endfunction

    function automatic void take_plain(logic [7:0] b);
        if (b == CH_QUOTE)
        begin
            add_res(8'h00, KIND_CLOSE, NO_CODE);
            clear_decoder();
        end
        else if (b < CH_SPACE)
            add_err(ERR_CONTROL_CHAR);
        else if (b == CH_BSLASH)
            dec_mode = MODE_ESC;
        else
            add_res(b, KIND_BYTE, NO_CODE);
    endfunction

    function automatic void take_escape(logic [7:0] b);
        logic [7:0] c;
        case (b)
            CH_QUOTE, CH_BSLASH, CH_SLASH: c = b;
            CH_B: c = 8'h08;
            CH_F: c = 8'h0C;
            CH_N: c = 8'h0A;
            CH_R: c = 8'h0D;
            CH_T: c = 8'h09;
            CH_U:
            begin
                open_hex(MODE_HEX);
                return;
            end
            default:
            begin
                add_err(ERR_UNKNOWN_ESC);
                return;
            end
        endcase
        dec_mode = MODE_PLAIN;
        add_res(c, KIND_BYTE, NO_CODE);
    endfunction

    // results of one input transaction, left in step_res
    function automatic void decode_step(in_item_t it);
        out_item_t tail;
        step_res.delete();
        if (it.end_of_input)
        begin
            case (dec_mode)
                MODE_ESC:            add_err(ERR_UNTERM_ESCAPE);
                MODE_HEX, MODE_HEX2: add_err(ERR_TRUNC_HEX);
                MODE_LEAD:
                begin
                    put_cp(CP_REPL);
                    add_err(ERR_UNTERM_STRING);
                end
                MODE_LEADBS:
                begin
                    put_cp(CP_REPL);
                    add_err(ERR_UNTERM_ESCAPE);
                end
                default:             add_err(ERR_UNTERM_STRING);
            endcase
        end
        else
        begin
            case (dec_mode)
                MODE_ESC:            take_escape(it.data_byte);
                MODE_HEX, MODE_HEX2: take_hex_digit(it.data_byte);
                MODE_LEAD:
                begin
                    if (it.data_byte == CH_BSLASH)
                        dec_mode = MODE_LEADBS;
                    else
                    begin
                        lead_hold = '0;
                        dec_mode  = MODE_PLAIN;
                        put_cp(CP_REPL);
                        take_plain(it.data_byte);
                    end
                end
                MODE_LEADBS:
                begin
                    if (it.data_byte == CH_U)
                        open_hex(MODE_HEX2);
                    else
                    begin
                        lead_hold = '0;
                        dec_mode  = MODE_ESC;
                        put_cp(CP_REPL);
                        take_escape(it.data_byte);
                    end
                end
                default:
                begin
                    dec_mode = MODE_PLAIN;
                    take_plain(it.data_byte);
                end
            endcase
        end
        // mark the final result of this transaction
        if (step_res.size() > 0)
        begin
            tail      = step_res.pop_back();
            tail.last = 1'b1;
            step_res  = {step_res, tail};
        end
    endfunction

    // ---------------------------------------------------------------
    // random stimulus planning
    // ---------------------------------------------------------------

    function automatic void plan_byte(logic [7:0] b);
        in_item_t it;
        it.data_byte    = b;
        it.end_of_input = 1'b0;
        plan_q          = {plan_q, it};
    endfunction

    function automatic void plan_end();
        in_item_t it;
        it.data_byte    = 8'($urandom_range(0, 255));
        it.end_of_input = 1'b1;
        plan_q          = {plan_q, it};
    endfunction

    function automatic logic [7:0] pick_text();
        logic [7:0] b;
        do
            b = 8'($urandom_range(8'h20, 8'hFF));
        while (b == CH_QUOTE || b == CH_BSLASH);
        return b;
    endfunction

    function automatic logic [7:0] pick_unknown_esc();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_U || b inside {SIMPLE_ESC});
        return b;
    endfunction

    function automatic logic [7:0] pick_nonhex();
        logic [7:0] b;
        logic [3:0] d;
        do
            b = 8'($urandom_range(0, 255));
        while (hex_nibble(b, d));
        return b;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + 8'(n);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n - 4'd10);
    endfunction

    function automatic logic [15:0] pick_lead();
        case ($urandom_range(0, 3))
            0:       return SUR_LEAD_LO;
            1:       return SUR_LEAD_HI;
            default: return SUR_LEAD_LO | 16'($urandom_range(0, 10'h3FF));
        endcase
    endfunction

    function automatic logic [15:0] pick_trail();
        case ($urandom_range(0, 3))
            0:       return SUR_TRAIL_LO;
            1:       return SUR_TRAIL_HI;
            default: return SUR_TRAIL_LO | 16'($urandom_range(0, 10'h3FF));
        endcase
    endfunction

    function automatic logic [15:0] pick_cp();
        case ($urandom_range(0, 4))
            0:       return 16'($urandom_range(0, 16'h7F));
            1:       return 16'($urandom_range(16'h80, 16'h7FF));
            2:       return 16'($urandom_range(16'h800, 16'hFFFF));
            3:       return pick_trail();
            default: return EDGE_CP[$urandom_range(0, 7)];
        endcase
    endfunction

    // \u escape with four digits; bad_at picks a digit to corrupt, -1 for none
    function automatic void plan_hex(logic [15:0] v, int bad_at);
        plan_byte(CH_BSLASH);
        plan_byte(CH_U);
        for (int i = 0; i < 4; i++)
        begin
            if (i == bad_at)
                plan_byte(pick_nonhex());
            else
                plan_byte(hex_char(v[(15 - 4 * i) -: 4]));
        end
    endfunction

    function automatic void plan_simple_esc();
        plan_byte(CH_BSLASH);
        if ($urandom_range(0, 3) == 0)
            plan_byte(pick_unknown_esc());
        else
            plan_byte(SIMPLE_ESC[$urandom_range(0, 7)]);
    endfunction

    // whatever can follow a held lead surrogate
    function automatic void plan_after_lead();
        case ($urandom_range(0, 7))
            0: plan_byte(pick_text());
            1: plan_byte(CH_QUOTE);
            2: plan_byte(8'($urandom_range(0, 8'h1F)));
            3: plan_simple_esc();
            4:
            begin
                if ($urandom_range(0, 1))
                    plan_hex(pick_lead(), -1);
                else
                    plan_hex(16'($urandom_range(16'h800, 16'hD7FF)), -1);
            end
            5: plan_end();
            6:
            begin
                plan_byte(CH_BSLASH);
                plan_end();
            end
            default: plan_hex(16'($urandom), $urandom_range(0, 3));
        endcase
    endfunction

    function automatic void plan_segment();
        in_item_t it;
        case ($urandom_range(0, 15))
            0, 1, 2, 3:
                repeat ($urandom_range(1, 8)) plan_byte(pick_text());
            4, 5:
                plan_simple_esc();
            6, 7, 8:
                plan_hex(pick_cp(), -1);
            9:
            begin
                plan_hex(pick_lead(), -1);
                plan_hex(pick_trail(), -1);
            end
            10:
            begin
                plan_hex(pick_lead(), -1);
                plan_after_lead();
            end
            11:
            begin
                if ($urandom_range(0, 1))
                    plan_hex(pick_lead(), -1);
                plan_hex(16'($urandom), $urandom_range(0, 3));
            end
            12:
            begin
                // text ends inside the hex digits
                if ($urandom_range(0, 1))
                    plan_hex(pick_lead(), -1);
                plan_byte(CH_BSLASH);
                plan_byte(CH_U);
                repeat ($urandom_range(0, 3)) plan_byte(hex_char(4'($urandom_range(0, 15))));
                plan_end();
            end
            13:
            begin
                case ($urandom_range(0, 2))
                    0:       plan_byte(CH_QUOTE);
                    1:       plan_end();
                    default: plan_byte(8'($urandom_range(0, 8'h1F)));
                endcase
            end
            default:
            begin
                // raw noise
                repeat ($urandom_range(1, 4))
                begin
                    it.data_byte    = 8'($urandom_range(0, 255));
                    it.end_of_input = ($urandom_range(0, 7) == 0);
                    plan_q          = {plan_q, it};
                end
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------

    // offer one transaction and book its results once accepted
    task automatic offer(in_item_t it, logic typed, out_item_t want);
        push <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (full);
        decode_step(it);
        if (typed)
            decoded_due = {decoded_due, want};
        else
            decoded_due = {decoded_due, step_res};
        // bursts of random length with random gaps between
        if (burst_left > 0)
            burst_left--;
        else
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
        end
    endtask

    // hold the input until every booked result has been taken
    task automatic wait_drained();
        push <= 1'b0;
        do
            @(posedge clk);
        while (decoded_due.size() != 0);
    endtask

    initial
    begin : stimulus
        in_item_t  it;
        out_item_t want;
        int        sent;
        rst_n      <= 1'b0;
        push       <= 1'b0;
        item       <= '0;
        errors     = 0;
        burst_left = 0;
        hold_req   = 1'b0;
        clear_decoder();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (DIRECTED[i])
        begin
            it.data_byte    = DIRECTED[i].data;
            it.end_of_input = DIRECTED[i].eoi;
            want.out_byte   = DIRECTED[i].wbyte;
            want.kind       = DIRECTED[i].wkind;
            want.error_code = DIRECTED[i].wcode;
            want.last       = 1'b1;
            offer(it, DIRECTED[i].typed, want);
        end
        wait_drained();

        // random part; the output side holds off for a while at its start
        hold_req = 1'b1;
        sent     = 0;
        while (sent < RANDOM_ITEMS)
        begin
            plan_segment();
            while (plan_q.size() > 0)
            begin
                offer(plan_q.pop_front(), 1'b0, '0);
                sent++;
                if (sent == PAUSE_AT)
                    wait_drained();
            end
        end

        // wait for the tail, then let the clock idle before the end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ---------------------------------------------------------------
    // output side: stall pattern and result checks
    // ---------------------------------------------------------------

    initial
    begin : collector
        out_item_t want;
        int        rx_cycle;
        int        hold_left;
        bit        held;
        pop       <= 1'b0;
        rx_cycle  = 0;
        hold_left = 0;
        held      = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            // compare an accepted result with the oldest booked one
            if (pop && !empty)
            begin
                if (decoded_due.size() == 0)
                begin
                    $error("result with nothing expected: out_byte %h kind %0d code %0d",
                           result.out_byte, result.kind, result.error_code);
                    errors++;
                end
                else
                begin
                    want = decoded_due.pop_front();
                    if (result.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %h, got %h", want.out_byte, result.out_byte);
                        errors++;
                    end
                    if (result.kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, result.kind);
                        errors++;
                    end
                    if (result.error_code !== want.error_code)
                    begin
                        $error("error_code: expected %0d, got %0d",
                               want.error_code, result.error_code);
                        errors++;
                    end
                    if (result.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, result.last);
                        errors++;
                    end
                end
            end
            // one long hold-off, then a rotating pop pattern
            rx_cycle++;
            if (hold_req && !held)
            begin
                hold_left = LONG_HOLD;
                held      = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                case (rx_cycle[7:6])
                    2'd1:    pop <= 1'($urandom_range(0, 1));
                    2'd2:    pop <= ($urandom_range(0, 3) == 0);
                    default: pop <= 1'b1;
                endcase
            end
        end
    end

    // run limit
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
